FILE: rtl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg
// shared types and constants of the congestion window controller
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

    // request kinds
    localparam logic REQ_ACK     = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // divider operand select
    localparam logic DIV_SEL_RWND = 1'b0;
    localparam logic DIV_SEL_SEG  = 1'b1;

    // fixed limits of the window fields
    localparam logic [1:0]  DUP_LIMIT = 2'd3;
    localparam logic [9:0]  RWND_MAX  = 10'd1023;
    localparam logic [15:0] CWND_MAX  = 16'hFFFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;         // input side may take a beat
        logic timeout;      // apply retransmission timeout
        logic rwnd_sat;     // receiver window saturates
        logic rwnd_div;     // receiver window from divider quotient
        logic dup;          // duplicate ack handling
        logic new_ack;      // new ack: bookkeeping and multiply
        logic ca_step;      // one avoidance increment
        logic ca_done;      // close the avoidance loop
        logic ss_cap;       // slow start capped at ssthresh
        logic ss_grow;      // slow start grows by divider quotient
        logic div_start;    // launch the divider
        logic div_sel;      // divider operands
        logic emit;         // load the result register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_fire;      // input beat accepted this cycle
        logic is_timeout;
        logic adv_big;      // advertised window saturates rwnd
        logic is_dup;
        logic is_new;
        logic slow_start;   // cwnd below ssthresh
        logic ca_more;      // another avoidance increment is due
        logic ss_cap_hit;   // acked bytes reach ssthresh
        logic div_done;
        logic out_free;     // result register can take a beat
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/cwc_req_if.sv
// ----------------------------------------------------------------------------
// cwc_req_if
// event channel: ack or timeout beats into the controller
// ----------------------------------------------------------------------------
`default_nettype none

interface cwc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] ack_num;
    logic [19:0] adv_window;

    modport source (output valid, output req_type, output ack_num, output adv_window,
                    input ready);
    modport sink   (input valid, input req_type, input ack_num, input adv_window,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/cwc_res_if.sv
// ----------------------------------------------------------------------------
// cwc_res_if
// result channel: window state after each event
// ----------------------------------------------------------------------------
`default_nettype none

interface cwc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] send_window;
    logic [15:0] cong_window;
    logic [15:0] slow_start_thresh;
    logic [9:0]  recv_window;
    logic        retransmit;
    logic [31:0] resend_seq;
    logic        ack_advanced;
    logic [31:0] freed_bytes;

    modport source (output valid, output send_window, output cong_window,
                    output slow_start_thresh, output recv_window, output retransmit,
                    output resend_seq, output ack_advanced, output freed_bytes,
                    input ready);
    modport sink   (input valid, input send_window, input cong_window,
                    input slow_start_thresh, input recv_window, input retransmit,
                    input resend_seq, input ack_advanced, input freed_bytes,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/cwc_div.sv
// ----------------------------------------------------------------------------
// cwc_div
// divider by the window unit or the segment size, reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_div #(
    parameter int UNIT = 1024,
    parameter int SEG  = 1012
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        sel,        // receiver window or segment count
    input  logic [31:0] dividend,   // segment path: below SEG * 2^16
    output logic        done,
    output logic [15:0] quotient
);
    import cwc_pkg::*;

    // floor(x / d) = (x * ceil(2^(n+l) / d)) >> (n+l) for x below 2^n,
    // l = ceil(log2 d)
    localparam int UNIT_L  = $clog2(UNIT);
    localparam int SEG_L   = $clog2(SEG);
    localparam int ADV_N   = 20;
    localparam int DLT_N   = 16 + SEG_L;
    localparam int SH_A    = ADV_N + UNIT_L;
    localparam int SH_B    = DLT_N + SEG_L;
    localparam int RCP_A_W = ADV_N + 1;
    localparam int RCP_B_W = DLT_N + 1;
    localparam int PRD_A_W = ADV_N + RCP_A_W;
    localparam int PRD_B_W = DLT_N + RCP_B_W;
    localparam longint unsigned RCP_A =
        ((64'd1 << SH_A) + 64'(UNIT) - 64'd1) / 64'(UNIT);
    localparam longint unsigned RCP_B =
        ((64'd1 << SH_B) + 64'(SEG) - 64'd1) / 64'(SEG);
    localparam logic [RCP_A_W-1:0] RCP_A_C = RCP_A_W'(RCP_A);
    localparam logic [RCP_B_W-1:0] RCP_B_C = RCP_B_W'(RCP_B);

    logic [PRD_A_W-1:0] prod_a;
    logic [PRD_B_W-1:0] prod_b;
    logic [15:0]        q_a;
    logic [15:0]        q_b;
    logic [15:0]        q_reg, q_next;
    logic               done_reg, done_next;

    assign prod_a = PRD_A_W'(dividend[ADV_N-1:0]) * PRD_A_W'(RCP_A_C);
    assign prod_b = PRD_B_W'(dividend[DLT_N-1:0]) * PRD_B_W'(RCP_B_C);
    assign q_a    = 16'(prod_a >> SH_A);
    assign q_b    = 16'(prod_b >> SH_B);

    always_comb
    begin
        q_next    = q_reg;
        done_next = start;
        if (start)
        begin
            q_next = (sel == DIV_SEL_SEG) ? q_b : q_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: rtl/cwc_dp.sv
// ----------------------------------------------------------------------------
// cwc_dp
// window state, multiplier, avoidance accumulator and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_dp #(
    parameter int WINDOW_UNIT  = 1024,
    parameter int HEADER_BYTES = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cwc_pkg::cmd_t cmd,
    output cwc_pkg::sts_t sts,
    cwc_req_if.sink       req,
    cwc_res_if.source     res
);
    import cwc_pkg::*;

    localparam int UNIT    = (WINDOW_UNIT > 0) ? WINDOW_UNIT : 1;
    localparam int SEG     = (WINDOW_UNIT > HEADER_BYTES) ? (WINDOW_UNIT - HEADER_BYTES) : 1;
    localparam int SEG_W   = $clog2(SEG + 1);
    localparam int PROD_W  = 16 + SEG_W;
    localparam int CMP_W   = (PROD_W > 33) ? PROD_W : 33;
    localparam logic [SEG_W-1:0]  SEG_C    = SEG_W'(SEG);
    localparam logic [31:0]       RWND_LIM = 32'(longint'(RWND_MAX) * longint'(UNIT));
    localparam logic [CMP_W-1:0]  ACC_TOP  = CMP_W'(32'hFFFF_FFFF);

    // window state
    logic [15:0]      cwnd_reg, cwnd_next;
    logic [15:0]      ssth_reg, ssth_next;
    logic [31:0]      hack_reg, hack_next;
    logic [1:0]       dup_reg, dup_next;
    logic [9:0]       rwnd_reg, rwnd_next;
    logic [31:0]      acc_reg, acc_next;
    // item and working registers
    logic             type_reg, type_next;
    logic [31:0]      ack_reg, ack_next;
    logic [19:0]      adv_reg, adv_next;
    logic [31:0]      delta_reg, delta_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CMP_W-1:0] wacc_reg, wacc_next;
    logic             rexmit_reg, rexmit_next;
    logic             advf_reg, advf_next;
    logic [31:0]      freed_reg, freed_next;
    // result register
    logic             res_valid_reg, res_valid_next;
    logic [15:0]      o_send_reg, o_send_next;
    logic [15:0]      o_cwnd_reg, o_cwnd_next;
    logic [15:0]      o_ssth_reg, o_ssth_next;
    logic [9:0]       o_rwnd_reg, o_rwnd_next;
    logic             o_rexmit_reg, o_rexmit_next;
    logic [31:0]      o_seq_reg, o_seq_next;
    logic             o_advf_reg, o_advf_next;
    logic [31:0]      o_freed_reg, o_freed_next;

    logic             in_fire;
    logic [15:0]      mul_a;
    logic [1:0]       dup_inc;
    logic [31:0]      div_dividend;
    logic             div_done;
    logic [15:0]      div_q;
    logic [15:0]      rwnd_ext;

    assign req.ready = cmd.take;
    assign in_fire   = req.valid && req.ready;

    assign sts.in_fire    = in_fire;
    assign sts.is_timeout = type_reg == REQ_TIMEOUT;
    assign sts.adv_big    = {12'd0, adv_reg} >= RWND_LIM;
    assign sts.is_dup     = ack_reg == hack_reg;
    assign sts.is_new     = ack_reg > hack_reg;
    assign sts.slow_start = cwnd_reg < ssth_reg;
    assign sts.ca_more    = (cwnd_reg != CWND_MAX) && (wacc_reg >= CMP_W'(prod_reg));
    assign sts.ss_cap_hit = CMP_W'(delta_reg) >= CMP_W'(prod_reg);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !res_valid_reg || res.ready;

    // shared constant divider: receiver window and slow start growth
    assign div_dividend = (cmd.div_sel == DIV_SEL_RWND) ? {12'd0, adv_reg} : delta_reg;

    cwc_div #(
        .UNIT (UNIT),
        .SEG  (SEG)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sel      (cmd.div_sel),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_a    = sts.slow_start ? (ssth_reg - cwnd_reg) : cwnd_reg;
    assign dup_inc  = (dup_reg < DUP_LIMIT) ? (dup_reg + 2'd1) : dup_reg;
    assign rwnd_ext = {6'd0, rwnd_reg};

    always_comb
    begin
        cwnd_next     = cwnd_reg;
        ssth_next     = ssth_reg;
        hack_next     = hack_reg;
        dup_next      = dup_reg;
        rwnd_next     = rwnd_reg;
        acc_next      = acc_reg;
        type_next     = type_reg;
        ack_next      = ack_reg;
        adv_next      = adv_reg;
        delta_next    = delta_reg;
        prod_next     = prod_reg;
        wacc_next     = wacc_reg;
        rexmit_next   = rexmit_reg;
        advf_next     = advf_reg;
        freed_next    = freed_reg;

        if (in_fire)
        begin
            type_next   = req.req_type;
            ack_next    = req.ack_num;
            adv_next    = req.adv_window;
            delta_next  = req.ack_num - hack_reg;
            rexmit_next = 1'b0;
            advf_next   = 1'b0;
            freed_next  = 32'd0;
        end
        if (cmd.timeout)
        begin
            ssth_next   = cwnd_reg >> 1;
            cwnd_next   = 16'd1;
            rexmit_next = 1'b1;
        end
        if (cmd.rwnd_sat)
        begin
            rwnd_next = RWND_MAX;
        end
        if (cmd.rwnd_div)
        begin
            // quotient is below the cap here, floor at one segment
            rwnd_next = (div_q == 16'd0) ? 10'd1 : div_q[9:0];
        end
        if (cmd.dup)
        begin
            dup_next = dup_inc;
            if (dup_inc == DUP_LIMIT)
            begin
                ssth_next   = cwnd_reg >> 1;
                cwnd_next   = cwnd_reg >> 1;
                rexmit_next = 1'b1;
            end
        end
        if (cmd.new_ack)
        begin
            dup_next   = 2'd0;
            advf_next  = 1'b1;
            freed_next = delta_reg;
            hack_next  = ack_reg;
            prod_next  = PROD_W'(mul_a) * PROD_W'(SEG_C);
            wacc_next  = CMP_W'(acc_reg) + CMP_W'(delta_reg);
        end
        if (cmd.ca_step)
        begin
            wacc_next = wacc_reg - CMP_W'(prod_reg);
            cwnd_next = cwnd_reg + 16'd1;
            prod_next = prod_reg + PROD_W'(SEG_C);
        end
        if (cmd.ca_done)
        begin
            acc_next = (wacc_reg > ACC_TOP) ? 32'hFFFF_FFFF : wacc_reg[31:0];
        end
        if (cmd.ss_cap)
        begin
            cwnd_next = ssth_reg;
            acc_next  = 32'd0;
        end
        if (cmd.ss_grow)
        begin
            cwnd_next = cwnd_reg + div_q;
            acc_next  = 32'd0;
        end
    end

    // result register, decoupled from the input side
    always_comb
    begin
        res_valid_next = res_valid_reg;
        o_send_next    = o_send_reg;
        o_cwnd_next    = o_cwnd_reg;
        o_ssth_next    = o_ssth_reg;
        o_rwnd_next    = o_rwnd_reg;
        o_rexmit_next  = o_rexmit_reg;
        o_seq_next     = o_seq_reg;
        o_advf_next    = o_advf_reg;
        o_freed_next   = o_freed_reg;
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
            o_send_next    = (cwnd_reg < rwnd_ext) ? cwnd_reg : rwnd_ext;
            o_cwnd_next    = cwnd_reg;
            o_ssth_next    = ssth_reg;
            o_rwnd_next    = rwnd_reg;
            o_rexmit_next  = rexmit_reg;
            o_seq_next     = hack_reg;
            o_advf_next    = advf_reg;
            o_freed_next   = freed_reg;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwnd_reg      <= 16'd1;
            ssth_reg      <= 16'd0;
            hack_reg      <= 32'd0;
            dup_reg       <= 2'd0;
            rwnd_reg      <= 10'd1;
            acc_reg       <= 32'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            hack_reg      <= hack_next;
            dup_reg       <= dup_next;
            rwnd_reg      <= rwnd_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        ack_reg      <= ack_next;
        adv_reg      <= adv_next;
        delta_reg    <= delta_next;
        prod_reg     <= prod_next;
        wacc_reg     <= wacc_next;
        rexmit_reg   <= rexmit_next;
        advf_reg     <= advf_next;
        freed_reg    <= freed_next;
        o_send_reg   <= o_send_next;
        o_cwnd_reg   <= o_cwnd_next;
        o_ssth_reg   <= o_ssth_next;
        o_rwnd_reg   <= o_rwnd_next;
        o_rexmit_reg <= o_rexmit_next;
        o_seq_reg    <= o_seq_next;
        o_advf_reg   <= o_advf_next;
        o_freed_reg  <= o_freed_next;
    end

    assign res.valid             = res_valid_reg;
    assign res.send_window       = o_send_reg;
    assign res.cong_window       = o_cwnd_reg;
    assign res.slow_start_thresh = o_ssth_reg;
    assign res.recv_window       = o_rwnd_reg;
    assign res.retransmit        = o_rexmit_reg;
    assign res.resend_seq        = o_seq_reg;
    assign res.ack_advanced      = o_advf_reg;
    assign res.freed_bytes       = o_freed_reg;

endmodule

`default_nettype wire

FILE: rtl/cwc_ctrl.sv
// ----------------------------------------------------------------------------
// cwc_ctrl
// sequencer for one event: classify, receiver window, growth, emit
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  cwc_pkg::sts_t sts,
    output cwc_pkg::cmd_t cmd
);
    import cwc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CLASSIFY  = 8'b0000_0010,
        ST_RWND_WAIT = 8'b0000_0100,
        ST_ACK       = 8'b0000_1000,
        ST_CA_LOOP   = 8'b0001_0000,
        ST_SS_CHECK  = 8'b0010_0000,
        ST_SS_WAIT   = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_SEL_RWND;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.in_fire)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (sts.is_timeout)
                begin
                    cmd.timeout = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (sts.adv_big)
                begin
                    cmd.rwnd_sat = 1'b1;
                    state_next   = ST_ACK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_RWND;
                    state_next    = ST_RWND_WAIT;
                end
            end
            ST_RWND_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.rwnd_div = 1'b1;
                    state_next   = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (sts.is_dup)
                begin
                    cmd.dup    = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (sts.is_new)
                begin
                    cmd.new_ack = 1'b1;
                    state_next  = sts.slow_start ? ST_SS_CHECK : ST_CA_LOOP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CA_LOOP:
            begin
                if (sts.ca_more)
                begin
                    cmd.ca_step = 1'b1;
                end
                else
                begin
                    cmd.ca_done = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_SS_CHECK:
            begin
                if (sts.ss_cap_hit)
                begin
                    cmd.ss_cap = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_SEG;
                    state_next    = ST_SS_WAIT;
                end
            end
            ST_SS_WAIT:
            begin
                cmd.div_sel = DIV_SEL_SEG;
                if (sts.div_done)
                begin
                    cmd.ss_grow = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/congestion_window_controller_top.sv
// ----------------------------------------------------------------------------
// congestion_window_controller_top
// reno-style congestion window controller: slow start, avoidance,
// triple duplicate ack and timeout handling, one result beat per event
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------------------
//  req      in   valid/ready    req_type, ack_num, adv_window
//  res      out  valid/ready    send_window, cong_window, slow_start_thresh,
//                               recv_window, retransmit, resend_seq,
//                               ack_advanced, freed_bytes
//
//  one event at a time; a timeout goes from accept straight to the result,
//  an ack first sets rwnd: saturated, or through the reciprocal multiply
//  new ack in slow start then caps at ssthresh or adds the divider quotient
//  new ack in avoidance takes one loop step per segment the window grows by
//  the result register lets the next beat be taken while a result waits
//  reset: cwnd 1, ssthresh 0, rwnd 1, ack mark, dup count, accumulator 0
// ----------------------------------------------------------------------------
`default_nettype none

module congestion_window_controller_top #(
    parameter int WINDOW_UNIT  = 1024,    // bytes per window unit
    parameter int HEADER_BYTES = 12       // header bytes inside one unit
) (
    input  logic      clk,
    input  logic      rst_n,
    cwc_req_if.sink   req,
    cwc_res_if.source res
);
    import cwc_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: one-hot state machine, one event in flight
    cwc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: window state, multiplier, shared divider, result register
    cwc_dp #(
        .WINDOW_UNIT  (WINDOW_UNIT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .res   (res)
    );

endmodule

`default_nettype wire

FILE: rtl/cwc_checker.sv
// ----------------------------------------------------------------------------
// cwc_checker
// port-level checks of the congestion window controller, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] send_window,
    input logic [15:0] cong_window,
    input logic [9:0]  recv_window,
    input logic        retransmit,
    input logic [31:0] resend_seq,
    input logic        ack_advanced,
    input logic [31:0] freed_bytes
);

    // one event in flight: no beat taken right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input beat taken while an event is in flight");

    // send window never above either window
    a_send_min: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (send_window <= cong_window)
                   && (send_window <= {6'd0, recv_window}))
        else $error("send window above congestion or receiver window");

    // retransmission and ack advance never together
    a_rexmit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(retransmit && ack_advanced))
        else $error("retransmit with advancing ack");

    // freed bytes only on an advancing ack
    a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !ack_advanced |-> freed_bytes == 32'd0)
        else $error("freed bytes without ack advance");

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(resend_seq)
                                 && $stable(cong_window))
        else $error("stalled result beat changed");

endmodule

bind congestion_window_controller_top cwc_checker u_cwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .send_window  (res.send_window),
    .cong_window  (res.cong_window),
    .recv_window  (res.recv_window),
    .retransmit   (res.retransmit),
    .resend_seq   (res.resend_seq),
    .ack_advanced (res.ack_advanced),
    .freed_bytes  (res.freed_bytes)
);

`default_nettype wire

FILE: tb/sv/tb_congestion_window_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_congestion_window_controller_top
// self-checking bench for the reno-style congestion window controller:
// a tracker class mirrors cwnd, ssthresh, rwnd, the ack mark, the duplicate
// count and the avoidance byte accumulator, predicts one result per accepted
// event beat and checks every result beat against the oldest prediction
// ----------------------------------------------------------------------------

module tb_congestion_window_controller_top;

    import cwc_pkg::*;

    // block parameters, shared with the tracker
    localparam int unsigned WINDOW_UNIT  = 1024;
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned SEG_BYTES    =
        (WINDOW_UNIT > HEADER_BYTES) ? (WINDOW_UNIT - HEADER_BYTES) : 1;

    // run control
    localparam int RANDOM_EVENTS  = 800;
    localparam int WATCHDOG_LIMIT = 20000;  // must outlast the longest avoidance loop
    localparam int DRAIN_CYCLES   = 64;
    localparam int REPORT_LIMIT   = 10;

    // one result beat as the bench sees it
    typedef struct {
        logic [15:0] send_window;
        logic [15:0] cong_window;
        logic [15:0] slow_start_thresh;
        logic [9:0]  recv_window;
        logic        retransmit;
        logic [31:0] resend_seq;
        logic        ack_advanced;
        logic [31:0] freed_bytes;
    } window_result_t;

    // ------------------------------------------------------------------------
    // tracker: window state mirror plus the queue of predicted result beats
    // ------------------------------------------------------------------------
    class cwnd_tracker;
        logic [15:0]    cwnd;
        logic [15:0]    ssthresh;
        logic [31:0]    ack_mark;
        logic [1:0]     dup_seen;
        logic [9:0]     rwnd;
        logic [31:0]    avoid_acc;
        window_result_t expected_windows[$];
        int             mismatches;

        function new();
            cwnd       = 16'd1;
            ssthresh   = 16'd0;
            ack_mark   = 32'd0;
            dup_seen   = 2'd0;
            rwnd       = 10'd1;
            avoid_acc  = 32'd0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        // predict the window state after one accepted event beat
        function void note_event(logic rt, logic [31:0] ack, logic [19:0] adv);
            window_result_t  exp_res;
            longint unsigned acc;
            longint unsigned grown;
            logic [31:0]     delta;
            int unsigned     segs;
            exp_res.retransmit   = 1'b0;
            exp_res.ack_advanced = 1'b0;
            exp_res.freed_bytes  = 32'd0;
            if (rt == REQ_TIMEOUT)
            begin
                ssthresh           = cwnd >> 1;
                cwnd               = 16'd1;
                exp_res.retransmit = 1'b1;
            end
            else
            begin
                segs = adv / WINDOW_UNIT;
                if (segs < 1)
                    segs = 1;
                if (segs > RWND_MAX)
                    segs = 32'(RWND_MAX);
                rwnd = segs[9:0];
                if (ack == ack_mark)
                begin
                    if (dup_seen < DUP_LIMIT)
                        dup_seen = dup_seen + 2'd1;
                    if (dup_seen == DUP_LIMIT)
                    begin
                        ssthresh           = cwnd >> 1;
                        cwnd               = ssthresh;
                        exp_res.retransmit = 1'b1;
                    end
                end
                else if (ack > ack_mark)
                begin
                    delta                = ack - ack_mark;
                    dup_seen             = 2'd0;
                    exp_res.ack_advanced = 1'b1;
                    exp_res.freed_bytes  = delta;
                    if (cwnd >= ssthresh)
                    begin
                        // avoidance: one segment per cwnd segments of acked bytes
                        acc = longint'(avoid_acc) + longint'(delta);
                        while (cwnd < CWND_MAX && acc >= longint'(cwnd) * SEG_BYTES)
                        begin
                            acc  = acc - longint'(cwnd) * SEG_BYTES;
                            cwnd = cwnd + 16'd1;
                        end
                        avoid_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    end
                    else
                    begin
                        // slow start: whole segments, capped at ssthresh
                        grown     = longint'(cwnd) + longint'(delta) / SEG_BYTES;
                        avoid_acc = 32'd0;
                        cwnd      = (grown >= longint'(ssthresh)) ? ssthresh : grown[15:0];
                    end
                    ack_mark = ack;
                end
            end
            exp_res.send_window       = (cwnd < {6'd0, rwnd}) ? cwnd : {6'd0, rwnd};
            exp_res.cong_window       = cwnd;
            exp_res.slow_start_thresh = ssthresh;
            exp_res.recv_window       = rwnd;
            exp_res.resend_seq        = ack_mark;
            expected_windows.push_back(exp_res);
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t %s: expected %h, got %h", $time, what, exp_val, act_val);
        endfunction

        function void check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val)
                flag(what, exp_val, act_val);
        endfunction

        function void check_result(window_result_t got);
            window_result_t exp_res;
            if (expected_windows.size() == 0)
            begin
                flag("unexpected result beat, cong_window", 32'd0, 32'(got.cong_window));
                return;
            end
            exp_res = expected_windows.pop_front();
            check_field("send_window",       32'(exp_res.send_window),
                        32'(got.send_window));
            check_field("cong_window",       32'(exp_res.cong_window),
                        32'(got.cong_window));
            check_field("slow_start_thresh", 32'(exp_res.slow_start_thresh),
                        32'(got.slow_start_thresh));
            check_field("recv_window",       32'(exp_res.recv_window),
                        32'(got.recv_window));
            check_field("retransmit",        32'(exp_res.retransmit),
                        32'(got.retransmit));
            check_field("resend_seq",        exp_res.resend_seq,        got.resend_seq);
            check_field("ack_advanced",      32'(exp_res.ack_advanced),
                        32'(got.ack_advanced));
            check_field("freed_bytes",       exp_res.freed_bytes,       got.freed_bytes);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    cwc_req_if req_ch ();
    cwc_res_if res_ch ();

    congestion_window_controller_top #(
        .WINDOW_UNIT  (WINDOW_UNIT),
        .HEADER_BYTES (HEADER_BYTES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    cwnd_tracker tracker;

    // stimulus side copy of the highest ack sent, used to shape sequences
    logic [31:0] sent_mark;
    int          burst_left;
    int          idle_cycles;

    // receiver stall pattern state
    int          ready_mode;
    int          mode_span;
    int          phase;
    int          on_len;
    int          period;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // event driver: one beat per call, bursts with random gaps between them
    // ------------------------------------------------------------------------
    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
    endtask

    task automatic send_event(input logic rt, input logic [31:0] ack, input logic [19:0] adv);
        @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.req_type   = rt;
        req_ch.ack_num    = ack;
        req_ch.adv_window = adv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // beat taken at this edge: predict its result
        tracker.note_event(rt, ack, adv);
        if (rt == REQ_ACK && ack > sent_mark)
            sent_mark = ack;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            // some bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 10));
        end
    endtask

    // advertised window: small values keep rwnd below cwnd, extremes hit the clamps
    function automatic logic [19:0] pick_adv();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1:       return 20'd1023;
            2:       return 20'd1024;
            3:       return 20'hFFFFF;
            4:       return 20'd1047552;
            5, 6:    return 20'($urandom);
            default: return 20'($urandom_range(0, 20 * 1024));
        endcase
    endfunction

    // bytes acked by one new ack: mostly whole segments, sometimes ragged or large
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 19))
            0:       return 32'($urandom_range(1, 3));
            1:       return 32'($urandom_range(1 << 16, 1 << 24));
            2, 3, 4, 5, 6, 7:
                     return 32'($urandom_range(1, 8 * SEG_BYTES));
            default: return 32'($urandom_range(1, 4) * SEG_BYTES);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int       count;
        int       dup_run;
        int       kind;
        logic [31:0] lo;
        tracker           = new();
        sent_mark         = 32'd0;
        burst_left        = 1;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ACK;
        req_ch.ack_num    = 32'd0;
        req_ch.adv_window = 20'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: triple duplicate right after reset drives cwnd to zero
        send_event(REQ_ACK, 32'd0, 20'd0);
        send_event(REQ_ACK, 32'd0, 20'd1023);
        send_event(REQ_ACK, 32'd0, 20'd1024);
        // duplicate count stays saturated, halving repeats
        send_event(REQ_ACK, 32'd0, 20'd2047);
        // zero cwnd grows to one for free, rwnd saturates
        send_event(REQ_ACK, 32'd1, 20'hFFFFF);
        send_event(REQ_ACK, 32'd1 + 5 * SEG_BYTES, 20'd1047552);
        send_event(REQ_ACK, 32'd1 + 25 * SEG_BYTES, 20'd1047551);
        // old ack only moves rwnd
        send_event(REQ_ACK, 32'd100, 20'd5000);
        // timeout ignores its payload and opens slow start
        send_event(REQ_TIMEOUT, 32'hFFFF_FFFF, 20'hFFFFF);
        send_event(REQ_ACK, sent_mark + SEG_BYTES, 20'hFFFFF);
        send_event(REQ_ACK, sent_mark + SEG_BYTES - 1, 20'hFFFFF);
        // slow start capped at ssthresh
        send_event(REQ_ACK, sent_mark + 100 * SEG_BYTES, 20'hFFFFF);
        // fresh triple duplicate halves the window
        repeat (4)
            send_event(REQ_ACK, sent_mark, 20'd8192);
        // back to back timeouts drive ssthresh to zero
        send_event(REQ_TIMEOUT, 32'd0, 20'd0);
        send_event(REQ_TIMEOUT, 32'h5555_AAAA, 20'hAAAAA);
        send_event(REQ_TIMEOUT, 32'd0, 20'd0);
        // ragged avoidance bytes pile up in the accumulator
        send_event(REQ_ACK, sent_mark + SEG_BYTES - 1, 20'd0);
        send_event(REQ_ACK, sent_mark + 2, 20'd3000);
        send_event(REQ_ACK, sent_mark + 7 * SEG_BYTES, 20'hFFFFF);

        // random: ack streams with duplicate runs, timeouts, stale and stray acks
        count = 0;
        while (count < RANDOM_EVENTS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                send_event(REQ_ACK, sent_mark + pick_delta(), pick_adv());
                count++;
            end
            else if (kind < 70)
            begin
                dup_run = $urandom_range(1, 5);
                repeat (dup_run)
                begin
                    send_event(REQ_ACK, sent_mark, pick_adv());
                    count++;
                end
            end
            else if (kind < 78)
            begin
                send_event(REQ_TIMEOUT, $urandom, 20'($urandom));
                count++;
            end
            else if (kind < 88)
            begin
                // stale ack below the mark
                send_event(REQ_ACK, (sent_mark == 0) ? 32'd0 : $urandom_range(0, sent_mark - 1),
                           pick_adv());
                count++;
            end
            else
            begin
                // stray beat somewhere around the mark, either kind
                lo = (sent_mark > 65535) ? sent_mark - 65535 : 32'd0;
                send_event(1'($urandom), $urandom_range(lo, sent_mark + 4096), 20'($urandom));
                count++;
            end
        end

        // closing: ack the top of the sequence space, then duplicates on it
        send_event(REQ_ACK, 32'hFFFF_FFFF, pick_adv());
        repeat (3)
            send_event(REQ_ACK, 32'hFFFF_FFFF, pick_adv());
        send_event(REQ_TIMEOUT, $urandom, 20'($urandom));
        send_event(REQ_ACK, 32'h7FFF_FFFF, 20'hFFFFF);
        @(negedge clk);
        req_ch.valid = 1'b0;

        // drain, then keep watching for anything stray
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("congestion_window_controller_top: match");
        else
            $display("congestion_window_controller_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: ready follows a stall pattern that changes every so often
    // ------------------------------------------------------------------------
    initial
    begin
        res_ch.ready = 1'b0;
        phase        = 0;
        stall_left   = 0;
        forever
        begin
            ready_mode = $urandom_range(0, 3);
            mode_span  = $urandom_range(32, 256);
            period     = $urandom_range(2, 9);
            on_len     = $urandom_range(1, period - 1);
            repeat (mode_span)
            begin
                @(negedge clk);
                case (ready_mode)
                    0: res_ch.ready = 1'b1;                       // no stalls
                    1: res_ch.ready = 1'($urandom);               // coin flip
                    2:
                    begin
                        // fixed on/off rhythm
                        res_ch.ready = (phase % period) < on_len;
                        phase++;
                    end
                    default:
                    begin
                        // mostly ready, rare long stalls
                        if (stall_left > 0)
                        begin
                            res_ch.ready = 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            res_ch.ready = 1'b1;
                            if ($urandom_range(0, 31) == 0)
                                stall_left = $urandom_range(5, 40);
                        end
                    end
                endcase
            end
        end
    end

    // result beats are checked at the edge that takes them
    always @(posedge clk)
    begin
        window_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.send_window       = res_ch.send_window;
            got.cong_window       = res_ch.cong_window;
            got.slow_start_thresh = res_ch.slow_start_thresh;
            got.recv_window       = res_ch.recv_window;
            got.retransmit        = res_ch.retransmit;
            got.resend_seq        = res_ch.resend_seq;
            got.ack_advanced      = res_ch.ack_advanced;
            got.freed_bytes       = res_ch.freed_bytes;
            tracker.check_result(got);
        end
    end

    // watchdog: too long without a beat on either channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("congestion_window_controller_top: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: sim.f
rtl/cwc_pkg.sv
rtl/cwc_req_if.sv
rtl/cwc_res_if.sv
rtl/cwc_div.sv
rtl/cwc_dp.sv
rtl/cwc_ctrl.sv
rtl/congestion_window_controller_top.sv
rtl/cwc_checker.sv
tb/sv/tb_congestion_window_controller_top.sv
